// File: rtl/positional_list_engine_top_assert.svh
// Assertion macros for the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PLE_ASSERT_IMPL(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PLE_ASSERT_IMPL(label, clk, rst, cond)
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ple_pkg.sv
`timescale 1ns / 1ps
package ple_pkg;
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] FUNC_INS_FIRST = 3'd0;
   localparam logic [2:0] FUNC_INS_LAST  = 3'd1;
   localparam logic [2:0] FUNC_INS_POS   = 3'd2;
   localparam logic [2:0] FUNC_DEL_FIRST = 3'd3;
   localparam logic [2:0] FUNC_DEL_LAST  = 3'd4;
   localparam logic [2:0] FUNC_DEL_POS   = 3'd5;
   localparam logic [2:0] FUNC_DUMP      = 3'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [IDX_W-1:0] idx;
      logic             dump_start;
      logic             dump_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CNT_W-1:0] fill;
      logic             dump_last;
   } stat_type;
endpackage

// File: rtl/ple_datapath.sv
`timescale 1ns / 1ps
`include "positional_list_engine_top_assert.svh"
module ple_datapath (
   input  logic               clock,
   input  logic               reset,
   input  ple_pkg::cmd_type   cmd,
   input  logic signed [31:0] value,
   output ple_pkg::stat_type  stat,
   output logic signed [31:0] rd_value
);
   logic signed [31:0] cells_ff [ple_pkg::DEPTH];
   logic signed [31:0] cells_in [ple_pkg::DEPTH];
   logic [ple_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic [ple_pkg::IDX_W-1:0] ptr_ff, ptr_in;

   // Every cell picks its own neighbour, so the whole row shifts together.
   always_comb begin
      for (int i = 0; i < ple_pkg::DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.ins) begin
            if (i == int'(cmd.idx)) cells_in[i] = value;
            else if (i > int'(cmd.idx)) cells_in[i] = cells_ff[i-1];
         end else if (cmd.del) begin
            if (i >= int'(cmd.idx) && i < ple_pkg::DEPTH - 1) cells_in[i] = cells_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ple_pkg::DEPTH; i++) cells_ff[i] <= cells_in[i];
   end

   // Fill count and dump read pointer.
   always_comb begin
      fill_in = fill_ff;
      if (cmd.ins) fill_in = fill_ff + 1'b1;
      else if (cmd.del) fill_in = fill_ff - 1'b1;
      ptr_in = ptr_ff;
      if (cmd.dump_start) ptr_in = '0;
      else if (cmd.dump_step) ptr_in = ptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         ptr_ff  <= ptr_in;
      end
   end

   assign rd_value       = cells_ff[ptr_ff];
   assign stat.fill      = fill_ff;
   assign stat.dump_last = ({1'b0, ptr_ff} + 1'b1) == fill_ff;

   `PLE_ASSERT_IMPL(a_fill_max, clock, reset, fill_ff <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
   `PLE_ASSERT_IMPL(a_no_ins_del, clock, reset, !(cmd.ins && cmd.del))
   `PLE_ASSERT_NEXT(a_ins_grows, clock, reset, cmd.ins, fill_ff == $past(fill_ff) + 1'b1)
endmodule

// File: rtl/ple_ctrl.sv
`timescale 1ns / 1ps
`include "positional_list_engine_top_assert.svh"
module ple_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2:0]        req_func,
   input  logic [7:0]        req_pos,
   input  ple_pkg::stat_type stat,
   output ple_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_strobe,
   output logic              rsp_ok,
   output logic              rsp_dump,
   output logic              rsp_last
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EDIT = 2'd1;
   localparam logic [1:0] ST_DUMP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       ok_ff, ok_in, empty_ff, empty_in;
   logic       full, empty, take, ok;
   logic [8:0] pos_m1;

   assign full   = stat.fill == ple_pkg::CNT_W'(ple_pkg::DEPTH);
   assign empty  = stat.fill == '0;
   assign take   = start && !busy;
   assign pos_m1 = {1'b0, req_pos} - 9'd1;

   // Decode the request into a shift command and its outcome.
   always_comb begin
      cmd = '0;
      ok  = 1'b0;
      case (req_func)
         ple_pkg::FUNC_INS_FIRST: ok = !full;
         ple_pkg::FUNC_INS_LAST: begin
            ok = !full;
            cmd.idx = ple_pkg::IDX_W'(stat.fill);
         end
         ple_pkg::FUNC_INS_POS: begin
            ok = !full && req_pos != 8'd0 && {1'b0, req_pos} <= {4'd0, stat.fill} + 9'd1;
            cmd.idx = ple_pkg::IDX_W'(pos_m1);
         end
         ple_pkg::FUNC_DEL_FIRST: ok = !empty;
         ple_pkg::FUNC_DEL_LAST: begin
            ok = !empty;
            cmd.idx = ple_pkg::IDX_W'(stat.fill - 1'b1);
         end
         ple_pkg::FUNC_DEL_POS: begin
            ok = req_pos != 8'd0 && {1'b0, req_pos} <= {4'd0, stat.fill};
            cmd.idx = ple_pkg::IDX_W'(pos_m1);
         end
         ple_pkg::FUNC_DUMP: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      if (take && ok) begin
         cmd.ins = req_func inside {ple_pkg::FUNC_INS_FIRST, ple_pkg::FUNC_INS_LAST,
                                    ple_pkg::FUNC_INS_POS};
         cmd.del = req_func inside {ple_pkg::FUNC_DEL_FIRST, ple_pkg::FUNC_DEL_LAST,
                                    ple_pkg::FUNC_DEL_POS};
      end
      cmd.dump_start = take && req_func == ple_pkg::FUNC_DUMP;
      cmd.dump_step  = state_ff == ST_DUMP && !empty_ff;
   end

   // Sequencer: edits report in the next cycle, dumps step through the row.
   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      empty_in = empty_ff;
      case (state_ff)
         ST_IDLE: if (take) begin
            ok_in    = ok;
            empty_in = empty;
            state_in = req_func == ple_pkg::FUNC_DUMP ? ST_DUMP : ST_EDIT;
         end
         ST_EDIT: state_in = ST_IDLE;
         ST_DUMP: if (empty_ff || stat.dump_last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ok_ff    <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
         empty_ff <= empty_in;
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = busy;
   assign rsp_ok     = state_ff == ST_DUMP ? 1'b1 : ok_ff;
   assign rsp_dump   = state_ff == ST_DUMP && !empty_ff;
   assign rsp_last   = state_ff == ST_EDIT || empty_ff || stat.dump_last;

   `PLE_ASSERT_NEXT(a_edit_one, clock, reset, state_ff == ST_EDIT, state_ff == ST_IDLE)
   `PLE_ASSERT_IMPL(a_cmd_idle, clock, reset, !(cmd.ins || cmd.del) || state_ff == ST_IDLE)
   `PLE_ASSERT_NEXT(a_last_idle, clock, reset, rsp_strobe && rsp_last, !busy)
endmodule

// File: rtl/positional_list_engine_top.sv
`timescale 1ns / 1ps
// Channel   | Ports                                   | Handshake
// request   | req_func, req_value, req_pos            | start high while busy low
// result    | rsp_ok, rsp_count, rsp_entry_value, ... | rsp_strobe, one cycle
// An edit gives its single result in the cycle after the request; a dump gives
// one result per entry on consecutive cycles, stepped by the read pointer.
// A dump of an empty list gives a single result with no entry. Synchronous reset
// empties the list. The receiver cannot stall; busy holds off new requests while
// results flow.
module positional_list_engine_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_pos,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic [4:0]         rsp_count,
   output logic signed [31:0] rsp_entry_value,
   output logic               rsp_entry_valid,
   output logic               rsp_last
);
   ple_pkg::cmd_type   cmd;
   ple_pkg::stat_type  stat;
   logic signed [31:0] rd_value;
   logic               dump;

   ple_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_func(req_func),
      .req_pos(req_pos), .stat(stat), .cmd(cmd), .busy(busy),
      .rsp_strobe(rsp_strobe), .rsp_ok(rsp_ok), .rsp_dump(dump), .rsp_last(rsp_last)
   );

   ple_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .value(req_value),
      .stat(stat), .rd_value(rd_value)
   );

   // Result fields.
   assign rsp_count       = 5'(stat.fill);
   assign rsp_entry_valid = dump;
   assign rsp_entry_value = dump ? rd_value : 32'sd0;
endmodule
